FILE: rtl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg: shared definitions for frustum box culling
// Fixed-point widths, plane count and sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package fbc_pkg;

  // Coordinate format: signed Q(COORD_WIDTH-FRAC_BITS).FRAC_BITS.
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // A plane coefficient is the exact sum or difference of two coordinates.
  localparam int COEF_W = COORD_WIDTH + 1;
  // Exact product of a coefficient and a coordinate.
  localparam int PROD_W = COEF_W + COORD_WIDTH;
  // Four products summed, with headroom.
  localparam int ACC_W  = PROD_W + 3;

  localparam int NUM_PLANES = 6;
  localparam int PLANE_W    = 3;
  localparam int STEP_W     = 2;
  localparam int ADDR_W     = PLANE_W + STEP_W;
  localparam int NUM_COEFS  = NUM_PLANES * 4;

  // Plane numbers in test order.
  localparam logic [PLANE_W-1:0] PLANE_LEFT   = 3'd0;
  localparam logic [PLANE_W-1:0] PLANE_RIGHT  = 3'd1;
  localparam logic [PLANE_W-1:0] PLANE_TOP    = 3'd2;
  localparam logic [PLANE_W-1:0] PLANE_BOTTOM = 3'd3;
  localparam logic [PLANE_W-1:0] PLANE_BACK   = 3'd4;
  localparam logic [PLANE_W-1:0] PLANE_FRONT  = 3'd5;
  localparam logic [PLANE_W-1:0] NONE_FAILED  = 3'd6;

  // Steps of a plane; STEP_D multiplies the constant term.
  localparam logic [STEP_W-1:0] STEP_X = 2'd0;
  localparam logic [STEP_W-1:0] STEP_Y = 2'd1;
  localparam logic [STEP_W-1:0] STEP_Z = 2'd2;
  localparam logic [STEP_W-1:0] STEP_D = 2'd3;

  // Item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEST = 1'b1;

  // Fixed-point one, used to align the constant term.
  localparam logic signed [COORD_WIDTH-1:0] FIX_ONE = COORD_WIDTH'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_LAST
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/frustum_box_culling.sv
// ----------------------------------------------------------------------------
// frustum_box_culling: positive-vertex frustum test of axis-aligned boxes
// Loads matrix columns into six clip planes and tests boxes against them
// with one shared multiplier, one product per cycle while no result waits on out_ready.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Fields
//   -------  --------------------  -------------------------------------------
//   in       in_valid / in_ready   kind, col_index, col_x..col_w, box_min_*,
//                                  box_max_*
//   out      out_valid / out_ready visible, failed_plane
//
// A load word is taken while idle and gives no result. A box test runs one
// step per plane coefficient (x, y, z, constant) on the shared 33x32
// multiplier plus one final check; a box that fails before the front plane
// finishes at the first step of the plane after it. Reset clears the plane
// table to zero and empties the result register. A result waiting on
// out_ready holds the final check; in_ready is high whenever no test runs.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_box_culling (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   kind,
  input  wire logic [1:0]                             col_index,
  input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0] col_x,
  input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0] col_y,
  input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0] col_z,
  input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0] col_w,
  input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0] box_min_x,
  input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0] box_min_y,
  input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0] box_min_z,
  input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0] box_max_x,
  input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0] box_max_y,
  input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0] box_max_z,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic                                        visible,
  output logic [2:0]                                  failed_plane
);

  // Plane table, entry plane*4 + column; column 3 is the constant term.
  logic signed [fbc_pkg::COEF_W-1:0] coeffs [fbc_pkg::NUM_COEFS];

  // Sequencer registers.
  fbc_pkg::state_t state, state_next;
  logic [fbc_pkg::PLANE_W-1:0] plane, plane_next;
  logic [fbc_pkg::STEP_W-1:0]  step, step_next;

  // Datapath registers.
  logic signed [fbc_pkg::COORD_WIDTH-1:0] bmin_x, bmin_y, bmin_z;
  logic signed [fbc_pkg::COORD_WIDTH-1:0] bmax_x, bmax_y, bmax_z;
  logic signed [fbc_pkg::PROD_W-1:0]      prod;
  logic signed [fbc_pkg::ACC_W-1:0]       acc;

  // Combinational signals.
  logic                                   accept;
  logic                                   out_free;
  logic                                   advance;
  logic                                   emit;
  logic                                   emit_visible;
  logic [fbc_pkg::PLANE_W-1:0]            emit_plane;
  logic signed [fbc_pkg::COEF_W-1:0]      coef;
  logic signed [fbc_pkg::COORD_WIDTH-1:0] opnd;
  logic signed [fbc_pkg::PROD_W-1:0]      mul_res;
  logic signed [fbc_pkg::ACC_W-1:0]       sum;
  logic                                   fail;
  logic signed [fbc_pkg::COEF_W-1:0]      w_ext, x_ext, y_ext, z_ext;

  assign in_ready = (state == fbc_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Shared multiplier: one coefficient times the matching box corner, or times fixed-point one for the constant term.
  assign coef = coeffs[{plane, step}];

  always_comb begin
    case (step)
      fbc_pkg::STEP_X: opnd = coef[fbc_pkg::COEF_W-1] ? bmin_x : bmax_x;
      fbc_pkg::STEP_Y: opnd = coef[fbc_pkg::COEF_W-1] ? bmin_y : bmax_y;
      fbc_pkg::STEP_Z: opnd = coef[fbc_pkg::COEF_W-1] ? bmin_z : bmax_z;
      default:         opnd = fbc_pkg::FIX_ONE;
    endcase
  end

  assign mul_res = fbc_pkg::PROD_W'(coef) * fbc_pkg::PROD_W'(opnd);

  // Plane value: three corner products plus the aligned constant term.
  assign sum  = acc + fbc_pkg::ACC_W'(prod);
  assign fail = sum[fbc_pkg::ACC_W-1] || (sum == '0);

  // Sequencer: next state, plane, step and result hand-off.
  always_comb begin
    state_next   = state;
    plane_next   = plane;
    step_next    = step;
    advance      = 1'b0;
    emit         = 1'b0;
    emit_visible = 1'b0;
    emit_plane   = fbc_pkg::NONE_FAILED;
    case (state)
      fbc_pkg::ST_IDLE: begin
        if (accept && (kind == fbc_pkg::KIND_TEST)) begin
          state_next = fbc_pkg::ST_RUN;
          plane_next = fbc_pkg::PLANE_LEFT;
          step_next  = fbc_pkg::STEP_X;
        end
      end
      fbc_pkg::ST_RUN: begin
        // The first step of each later plane checks the plane before it.
        if ((step == fbc_pkg::STEP_X) && (plane != fbc_pkg::PLANE_LEFT) && fail) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_plane = plane - fbc_pkg::PLANE_W'(1);
            state_next = fbc_pkg::ST_IDLE;
          end
        end else begin
          advance   = 1'b1;
          step_next = step + fbc_pkg::STEP_W'(1);
          if (step == fbc_pkg::STEP_D) begin
            if (plane == fbc_pkg::PLANE_FRONT) begin
              state_next = fbc_pkg::ST_LAST;
            end else begin
              plane_next = plane + fbc_pkg::PLANE_W'(1);
            end
          end
        end
      end
      fbc_pkg::ST_LAST: begin
        if (out_free) begin
          emit         = 1'b1;
          emit_visible = !fail;
          emit_plane   = fail ? fbc_pkg::PLANE_FRONT : fbc_pkg::NONE_FAILED;
          state_next   = fbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbc_pkg::ST_IDLE;
      plane <= fbc_pkg::PLANE_LEFT;
      step  <= fbc_pkg::STEP_X;
    end else begin
      state <= state_next;
      plane <= plane_next;
      step  <= step_next;
    end
  end

  // Product register and running sum.
  always_ff @(posedge clk) begin
    if (advance) begin
      prod <= mul_res;
      case (step)
        fbc_pkg::STEP_X: acc <= acc;
        fbc_pkg::STEP_Y: acc <= fbc_pkg::ACC_W'(prod);
        default:         acc <= sum;
      endcase
    end
  end

  // Box bounds are captured with the test word.
  always_ff @(posedge clk) begin
    if (accept && (kind == fbc_pkg::KIND_TEST)) begin
      bmin_x <= box_min_x;
      bmin_y <= box_min_y;
      bmin_z <= box_min_z;
      bmax_x <= box_max_x;
      bmax_y <= box_max_y;
      bmax_z <= box_max_z;
    end
  end

  // Plane table: a load word writes one column of all six planes.
  assign w_ext = fbc_pkg::COEF_W'(col_w);
  assign x_ext = fbc_pkg::COEF_W'(col_x);
  assign y_ext = fbc_pkg::COEF_W'(col_y);
  assign z_ext = fbc_pkg::COEF_W'(col_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fbc_pkg::NUM_COEFS; i++) begin
        coeffs[i] <= '0;
      end
    end else if (accept && (kind == fbc_pkg::KIND_LOAD)) begin
      coeffs[{fbc_pkg::PLANE_LEFT,   col_index}] <= w_ext + x_ext;
      coeffs[{fbc_pkg::PLANE_RIGHT,  col_index}] <= w_ext - x_ext;
      coeffs[{fbc_pkg::PLANE_TOP,    col_index}] <= w_ext - y_ext;
      coeffs[{fbc_pkg::PLANE_BOTTOM, col_index}] <= w_ext + y_ext;
      coeffs[{fbc_pkg::PLANE_BACK,   col_index}] <= w_ext + z_ext;
      coeffs[{fbc_pkg::PLANE_FRONT,  col_index}] <= w_ext - z_ext;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      visible      <= emit_visible;
      failed_plane <= emit_plane;
    end
  end

endmodule

`default_nettype wire
